// ----- rtl/sdmct_pkg.sv -----
// Shared types and constants for the split direct-mapped cache tag store.
// Address split, access codes, controller state and command struct.
// No dependencies.
package sdmct_pkg;

    localparam int SETS        = 256;
    localparam int BLOCK_BYTES = 64;
    localparam int ADDR_BITS   = 48;

    localparam int OFF_BITS = $clog2(BLOCK_BYTES);
    localparam int IDX_BITS = $clog2(SETS);
    localparam int TAG_BITS = ADDR_BITS - OFF_BITS - IDX_BITS;
    localparam int CNT_BITS = 32;

    localparam int OP_BITS   = 2;
    localparam int IN_BYTES  = (ADDR_BITS + 7) / 8;
    localparam int IN_W      = IN_BYTES * 8;
    localparam int RES_BITS  = 2 + 2 * CNT_BITS;
    localparam int OUT_BYTES = (RES_BITS + 7) / 8;
    localparam int OUT_W     = OUT_BYTES * 8;

    typedef enum logic [OP_BITS-1:0] {
        OP_DREAD  = 2'd0,
        OP_DWRITE = 2'd1,
        OP_IFETCH = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_CLEAR = 2'd0,
        ST_IDLE  = 2'd1,
        ST_LOOK  = 2'd2
    } t_state;

    typedef struct packed {
        logic clear;
        logic capture;
        logic finish;
    } t_ctrl;

endpackage

// ----- rtl/split_direct_mapped_cache_tags.sv -----
// Split instruction/data direct-mapped cache tag store, 256 sets x 64-byte
// blocks each, with saturating per-cache hit and miss counters.
// Input beat: tuser = access op (0 data read, 1 data write, 2 fetch,
// 3 no access), tdata = 48-bit byte address.
// Output beat: tdata = {pad, miss_total, hit_total, writeback, hit}; the
// counts are those of the cache the access used (data cache for op 3).
// For each beat, the line is read into a register at the accepting edge,
// and compare, line update and counter update finish in the lookup state,
// once the output register is free. Output tvalid rises when the lookup
// finishes; no new input beat is taken before the lookup has finished.
// The result sits in an output register, so the next input beat is taken
// while it waits; if the receiver stalls, the following lookup holds until
// the output register frees up, and input tready stays low meanwhile.
// Reset (i_rst_n low, synchronous) clears the counters at once and starts a
// clearing pass over all 256 lines, which hold the valid and dirty bits;
// input tready stays low until the pass ends.
// Depends on sdmct_pkg, sdmct_ctrl and sdmct_dpath.
module split_direct_mapped_cache_tags (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [sdmct_pkg::IN_W-1:0]        i_s_tdata,   // address
    input  logic [sdmct_pkg::OP_BITS-1:0]     i_s_tuser,   // op
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [sdmct_pkg::OUT_W-1:0]       o_m_tdata    // hit, writeback, hit_total, miss_total, pad
);

    sdmct_pkg::t_ctrl w_ctrl;
    logic             w_clr_done;

    sdmct_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_clr_done (w_clr_done),
        .o_ctrl     (w_ctrl)
    );

    sdmct_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (w_ctrl),
        .i_op       (i_s_tuser),
        .i_addr     (i_s_tdata[sdmct_pkg::ADDR_BITS-1:0]),
        .o_clr_done (w_clr_done),
        .o_result   (o_m_tdata)
    );

endmodule

// ----- rtl/sdmct_ctrl.sv -----
// Controller for the split cache tag store: post-reset line clearing,
// accept / lookup sequencing and the result beat valid flag. Uses sdmct_pkg.
module sdmct_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    input  logic                i_clr_done,
    output sdmct_pkg::t_ctrl    o_ctrl
);

    sdmct_pkg::t_state r_state, n_state;
    logic              r_out_valid, n_out_valid;
    logic              w_out_free;

    assign w_out_free = !r_out_valid || i_m_tready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sdmct_pkg::ST_CLEAR: begin
                if (i_clr_done) n_state = sdmct_pkg::ST_IDLE;
            end
            sdmct_pkg::ST_IDLE: begin
                if (i_s_tvalid) n_state = sdmct_pkg::ST_LOOK;
            end
            sdmct_pkg::ST_LOOK: begin
                if (w_out_free) n_state = sdmct_pkg::ST_IDLE;
            end
            default: n_state = sdmct_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_s_tready     = 1'b0;
        o_ctrl.clear   = 1'b0;
        o_ctrl.capture = 1'b0;
        o_ctrl.finish  = 1'b0;
        unique case (r_state)
            sdmct_pkg::ST_CLEAR: begin
                o_ctrl.clear = 1'b1;
            end
            sdmct_pkg::ST_IDLE: begin
                o_s_tready     = 1'b1;
                o_ctrl.capture = i_s_tvalid;
            end
            sdmct_pkg::ST_LOOK: begin
                o_ctrl.finish = w_out_free;
            end
            default: ;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_ctrl.finish) n_out_valid = 1'b1;
        else if (i_m_tready) n_out_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sdmct_pkg::ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_m_tvalid = r_out_valid;

endmodule

// ----- rtl/sdmct_dpath.sv -----
// Datapath for the split cache tag store: line memories holding tag, valid
// and dirty bits, clearing counter, saturating counters and the result
// register. Uses sdmct_pkg.
module sdmct_dpath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sdmct_pkg::t_ctrl              i_ctrl,
    input  logic [sdmct_pkg::OP_BITS-1:0] i_op,
    input  logic [sdmct_pkg::ADDR_BITS-1:0] i_addr,
    output logic                          o_clr_done,
    output logic [sdmct_pkg::OUT_W-1:0]   o_result
);

    localparam int IB = sdmct_pkg::IDX_BITS;
    localparam int TB = sdmct_pkg::TAG_BITS;
    localparam int OB = sdmct_pkg::OFF_BITS;
    localparam int CB = sdmct_pkg::CNT_BITS;
    localparam logic [CB-1:0] CNT_MAX = '1;

    // data line {dirty, valid, tag}, fetch line {valid, tag}
    logic [TB+1:0] r_dmem [sdmct_pkg::SETS];
    logic [TB:0]   r_imem [sdmct_pkg::SETS];
    logic [TB+1:0] r_drd;
    logic [TB:0]   r_ird;
    logic [IB-1:0] r_clr_idx;

    logic [CB-1:0] r_dhit_cnt, r_dmiss_cnt, r_ihit_cnt, r_imiss_cnt;

    sdmct_pkg::t_op                  r_op;
    logic [sdmct_pkg::ADDR_BITS-1:0] r_addr;

    logic          r_hit, r_wb;
    logic [CB-1:0] r_hit_tot, r_miss_tot;

    logic [IB-1:0] w_idx, w_rd_idx;
    logic [TB-1:0] w_tag;
    logic          w_is_data, w_is_inst, w_dhit, w_ihit, w_wb;
    logic          w_dvalid, w_ddirty, w_ivalid, w_dwr, w_new_dirty;
    logic          w_dhit_inc, w_dmiss_inc, w_ihit_inc, w_imiss_inc;
    logic [CB-1:0] n_dhit_cnt, n_dmiss_cnt, n_ihit_cnt, n_imiss_cnt;

    assign w_rd_idx = i_addr[OB +: IB];
    assign w_idx    = r_addr[OB +: IB];
    assign w_tag    = r_addr[OB + IB +: TB];

    assign w_dvalid = r_drd[TB];
    assign w_ddirty = r_drd[TB+1];
    assign w_ivalid = r_ird[TB];

    assign w_is_data = (r_op == sdmct_pkg::OP_DREAD) || (r_op == sdmct_pkg::OP_DWRITE);
    assign w_is_inst = (r_op == sdmct_pkg::OP_IFETCH);
    assign w_dhit    = w_dvalid && (r_drd[TB-1:0] == w_tag);
    assign w_ihit    = w_ivalid && (r_ird[TB-1:0] == w_tag);
    assign w_wb      = w_is_data && !w_dhit && w_dvalid && w_ddirty;

    assign w_dwr       = i_ctrl.finish && w_is_data;
    assign w_new_dirty = (r_op == sdmct_pkg::OP_DWRITE) || (w_dhit && w_ddirty);

    assign w_dhit_inc  = i_ctrl.finish && w_is_data && w_dhit;
    assign w_dmiss_inc = i_ctrl.finish && w_is_data && !w_dhit;
    assign w_ihit_inc  = i_ctrl.finish && w_is_inst && w_ihit;
    assign w_imiss_inc = i_ctrl.finish && w_is_inst && !w_ihit;

    assign n_dhit_cnt  = (w_dhit_inc  && r_dhit_cnt  != CNT_MAX) ? r_dhit_cnt  + 1'b1 : r_dhit_cnt;
    assign n_dmiss_cnt = (w_dmiss_inc && r_dmiss_cnt != CNT_MAX) ? r_dmiss_cnt + 1'b1 : r_dmiss_cnt;
    assign n_ihit_cnt  = (w_ihit_inc  && r_ihit_cnt  != CNT_MAX) ? r_ihit_cnt  + 1'b1 : r_ihit_cnt;
    assign n_imiss_cnt = (w_imiss_inc && r_imiss_cnt != CNT_MAX) ? r_imiss_cnt + 1'b1 : r_imiss_cnt;

    assign o_clr_done = (r_clr_idx == '1);

    // line memories: cleared after reset, read at capture, updated at finish
    always_ff @(posedge i_clk) begin
        if (i_ctrl.capture) begin
            r_drd <= r_dmem[w_rd_idx];
            r_ird <= r_imem[w_rd_idx];
        end
        if (i_ctrl.clear) begin
            r_dmem[r_clr_idx] <= '0;
            r_imem[r_clr_idx] <= '0;
        end else begin
            if (w_dwr) r_dmem[w_idx] <= {w_new_dirty, 1'b1, w_tag};
            if (w_imiss_inc) r_imem[w_idx] <= {1'b1, w_tag};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.capture) begin
            r_op   <= sdmct_pkg::t_op'(i_op);
            r_addr <= i_addr;
        end
        if (i_ctrl.finish) begin
            r_hit <= (w_is_data && w_dhit) || (w_is_inst && w_ihit);
            r_wb  <= w_wb;
            if (w_is_inst) begin
                r_hit_tot  <= n_ihit_cnt;
                r_miss_tot <= n_imiss_cnt;
            end else begin
                r_hit_tot  <= n_dhit_cnt;
                r_miss_tot <= n_dmiss_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx   <= '0;
            r_dhit_cnt  <= '0;
            r_dmiss_cnt <= '0;
            r_ihit_cnt  <= '0;
            r_imiss_cnt <= '0;
        end else begin
            if (i_ctrl.clear) r_clr_idx <= r_clr_idx + 1'b1;
            r_dhit_cnt  <= n_dhit_cnt;
            r_dmiss_cnt <= n_dmiss_cnt;
            r_ihit_cnt  <= n_ihit_cnt;
            r_imiss_cnt <= n_imiss_cnt;
        end
    end

    assign o_result = {{(sdmct_pkg::OUT_W - sdmct_pkg::RES_BITS){1'b0}},
                       r_miss_tot, r_hit_tot, r_wb, r_hit};

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for split_direct_mapped_cache_tags: directed and
// random data/fetch accesses checked against a behavioral tag-store scoreboard.
// Depends on sdmct_pkg and the split_direct_mapped_cache_tags RTL.
`timescale 1ns / 100ps

module tb;
    import sdmct_pkg::*;

    localparam int CYCLE_LIMIT = 100000;
    localparam int RANDOM_ACCESSES = 500;

    typedef struct {
        logic        hit;
        logic        writeback;
        logic [31:0] hits;
        logic [31:0] misses;
    } lookup_t;

    class cache_scoreboard;
        bit [TAG_BITS-1:0] dtag [SETS];
        bit [TAG_BITS-1:0] itag [SETS];
        bit                dvalid [SETS];
        bit                ddirty [SETS];
        bit                ivalid [SETS];
        bit [31:0]         dhits, dmisses, ihits, imisses;
        lookup_t           expected_q [$];
        int                errors;
        int                accepted;
        int                checked;
        int                n_hits;
        int                n_writebacks;
        int                op_count [4];

        function bit [31:0] sat_inc(bit [31:0] c);
            return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
        endfunction

        function void note_access(t_op op, logic [ADDR_BITS-1:0] addr);
            lookup_t           e;
            bit [IDX_BITS-1:0] set;
            bit [TAG_BITS-1:0] tag;
            set = addr[OFF_BITS +: IDX_BITS];
            tag = addr[ADDR_BITS-1 -: TAG_BITS];
            e.hit = 1'b0;
            e.writeback = 1'b0;
            accepted++;
            op_count[op]++;
            case (op)
                OP_DREAD, OP_DWRITE: begin
                    if (dvalid[set] && dtag[set] == tag) begin
                        e.hit = 1'b1;
                        dhits = sat_inc(dhits);
                        if (op == OP_DWRITE) ddirty[set] = 1'b1;
                    end else begin
                        e.writeback = dvalid[set] && ddirty[set];
                        dmisses = sat_inc(dmisses);
                        dtag[set] = tag;
                        dvalid[set] = 1'b1;
                        ddirty[set] = (op == OP_DWRITE);
                    end
                    e.hits = dhits;
                    e.misses = dmisses;
                end
                OP_IFETCH: begin
                    if (ivalid[set] && itag[set] == tag) begin
                        e.hit = 1'b1;
                        ihits = sat_inc(ihits);
                    end else begin
                        imisses = sat_inc(imisses);
                        itag[set] = tag;
                        ivalid[set] = 1'b1;
                    end
                    e.hits = ihits;
                    e.misses = imisses;
                end
                default: begin
                    e.hits = dhits;
                    e.misses = dmisses;
                end
            endcase
            n_hits += e.hit;
            n_writebacks += e.writeback;
            expected_q.push_back(e);
        endfunction

        function void check_result(logic [OUT_W-1:0] beat);
            lookup_t e;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("ERROR: unexpected result beat %h", beat);
                return;
            end
            e = expected_q.pop_front();
            checked++;
            if (beat[0] !== e.hit || beat[1] !== e.writeback ||
                beat[2 +: 32] !== e.hits || beat[34 +: 32] !== e.misses) begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: result %0d exp hit=%b wb=%b hits=%0d misses=%0d, got hit=%b wb=%b hits=%0d misses=%0d",
                             checked, e.hit, e.writeback, e.hits, e.misses,
                             beat[0], beat[1], beat[2 +: 32], beat[34 +: 32]);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [IN_W-1:0]     s_tdata = '0;    // address
    logic [OP_BITS-1:0]  s_tuser = '0;    // op
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [OUT_W-1:0]    m_tdata;         // hit, writeback, hit_total, miss_total, pad

    cache_scoreboard sb = new;
    bit              burst = 1'b0;
    bit              holdoff_done = 1'b0;
    int              holdoff_left = 0;
    int              cycles = 0;

    logic [TAG_BITS-1:0] tag_pool [4];
    logic [IDX_BITS-1:0] set_pool [4];

    split_direct_mapped_cache_tags i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    // Result sink: random stalls, a long hold-off once, none during bursts.
    always @(negedge i_clk) begin
        if (holdoff_left > 0) begin
            holdoff_left <= holdoff_left - 1;
            m_tready <= 1'b0;
        end else if (!holdoff_done && sb.accepted >= 60) begin
            holdoff_done <= 1'b1;
            holdoff_left <= 80;
            m_tready <= 1'b0;
        end else if (burst) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= 35);
        end
    end

    task automatic send_access(t_op op, logic [ADDR_BITS-1:0] addr);
        while (!burst && $urandom_range(99) < 35) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= IN_W'(addr);
        s_tuser <= op;
        do @(posedge i_clk); while (!s_tready);
        sb.note_access(op, addr);
        @(negedge i_clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(negedge i_clk); while (sb.pending() != 0);
    endtask

    function automatic logic [ADDR_BITS-1:0] mk_addr(logic [TAG_BITS-1:0] tag,
                                                     logic [IDX_BITS-1:0] set,
                                                     logic [OFF_BITS-1:0] off);
        return {tag, set, off};
    endfunction

    task automatic random_access(output t_op op, output logic [ADDR_BITS-1:0] addr);
        int r;
        r = $urandom_range(99);
        op = (r < 35) ? OP_DREAD : (r < 65) ? OP_DWRITE : (r < 95) ? OP_IFETCH : OP_NONE;
        if ($urandom_range(99) < 75)
            addr = mk_addr(tag_pool[$urandom_range(3)], set_pool[$urandom_range(3)],
                           OFF_BITS'($urandom));
        else
            addr = ADDR_BITS'({$urandom, $urandom});
    endtask

    initial begin
        t_op                 op;
        logic [ADDR_BITS-1:0] addr;
        logic [ADDR_BITS-1:0] all1;
        bit                  failed;

        all1 = '1;
        tag_pool[0] = '0;
        tag_pool[1] = '1;
        tag_pool[2] = TAG_BITS'({$urandom, $urandom});
        tag_pool[3] = TAG_BITS'({$urandom, $urandom});
        set_pool[0] = '0;
        set_pool[1] = '1;
        set_pool[2] = IDX_BITS'($urandom);
        set_pool[3] = IDX_BITS'($urandom);

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: read/write hit and miss, dirty kept on read hit, dirty and
        // clean eviction, fetch side, address extremes, unused opcode.
        send_access(OP_DREAD,  '0);
        send_access(OP_DREAD,  '0);
        send_access(OP_DWRITE, mk_addr('0, '0, '1));
        send_access(OP_DREAD,  '0);
        send_access(OP_DREAD,  mk_addr('1, '0, '0));
        send_access(OP_DREAD,  mk_addr('0, '0, 6'd17));
        send_access(OP_DWRITE, all1);
        send_access(OP_DWRITE, all1);
        send_access(OP_DWRITE, mk_addr(TAG_BITS'(1), '1, '0));
        send_access(OP_DREAD,  all1);
        send_access(OP_IFETCH, '0);
        send_access(OP_IFETCH, '0);
        send_access(OP_IFETCH, all1);
        send_access(OP_IFETCH, mk_addr(TAG_BITS'(5), '1, '0));
        send_access(OP_IFETCH, all1);
        send_access(OP_NONE,   all1);
        send_access(OP_NONE,   '0);
        send_access(OP_DREAD,  mk_addr('0, '0, 6'd33));
        drain();

        for (int n = 0; n < RANDOM_ACCESSES; n++) begin
            burst = (n >= 200 && n < 300);
            if (n == 400) drain();
            random_access(op, addr);
            send_access(op, addr);
        end
        burst = 1'b0;
        s_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        failed = (sb.errors != 0) || (sb.pending() != 0);
        $display("Ran %0d accesses: %0d data reads, %0d data writes, %0d fetches, %0d no-ops",
                 sb.accepted, sb.op_count[OP_DREAD], sb.op_count[OP_DWRITE],
                 sb.op_count[OP_IFETCH], sb.op_count[OP_NONE]);
        $display("%0d results checked with %0d hits and %0d writebacks, %0d mismatches",
                 sb.checked, sb.n_hits, sb.n_writebacks, sb.errors);
        if (!failed) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
